[rtl/cdr_pkg.sv]
package cdr_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned ChunkBits  = 32;
  localparam int unsigned PendBits   = WordBits + 2;
  localparam int unsigned BufBits    = PendBits + ChunkBits;
  localparam int unsigned CntBits    = $clog2(BufBits + 1);
  localparam int unsigned DictDepth  = 8;
  localparam int unsigned DictIdxW   = $clog2(DictDepth);
  localparam int unsigned CfgIdxBits = 4;
  localparam int unsigned CfgBits    = 32;
  localparam int unsigned RepBits    = 2;
  localparam int unsigned ShiftBits  = 6;

  // code prefixes
  localparam logic [2:0] PfxRaw  = 3'b110;
  localparam logic [2:0] PfxDict = 3'b101;
  localparam logic [2:0] PfxRun  = 3'b000;

  // code lengths in bits
  localparam int unsigned PfxLen  = 3;
  localparam int unsigned RawLen  = PfxLen + WordBits;
  localparam int unsigned DictLen = PfxLen + DictIdxW;
  localparam int unsigned RunLen  = PfxLen + RepBits;

  typedef enum logic [1:0] {
    KindWord      = 2'd0,
    KindBadPrefix = 2'd1,
    KindNoPrior   = 2'd2
  } res_kind_e;

  typedef enum logic [1:0] {
    StIdle   = 2'b01,
    StDecode = 2'b10
  } state_e;

  typedef struct packed {
    logic [ChunkBits-1:0] stream_chunk;
    logic                 end_of_stream;
  } in_req_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [WordBits-1:0] decoded_word;
    logic                last_of_run;
  } out_res_t;

  // one decode step, from the code unit to the sequencer
  typedef struct packed {
    logic                emit;
    res_kind_e           kind;
    logic [WordBits-1:0] word;
    logic                set_prev;
    logic [RepBits-1:0]  rep_next;
  } step_t;

endpackage

[rtl/cdr_stream_if.sv]
interface cdr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/code_decompressor_dict_rle_unit.sv]
// channel  dir  payload                                      handshake
// req_i    in   stream_chunk[31:0], end_of_stream            valid/ready
// res_o    out  result_kind[1:0], decoded_word[31:0],        valid/ready
//               last_of_run
// cfg      in   cfg_we_i, cfg_idx_i[3:0], cfg_data_i[31:0]    write on we
//
// the idle state loads a request, the decode state gives one result a cycle,
// then a closing step returns to idle (runs give one word a cycle); the
// shared code unit decodes one code or one repeat a cycle, all unless stalled
// a result waits in a hold register so last_of_run is known when it leaves
// decoding stalls while the output register is full and not taken
// reset clears the dictionary, carried bits and the previous word
module code_decompressor_dict_rle_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cdr_stream_if.sink                     req_i,
  cdr_stream_if.source                   res_o,
  input  logic                           cfg_we_i,
  input  logic [cdr_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [cdr_pkg::CfgBits-1:0]    cfg_data_i
);
  import cdr_pkg::*;

  state_e               state_q, state_d;
  logic [BufBits-1:0]   buf_q, buf_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 eos_q, eos_d;
  logic [WordBits-1:0]  prev_word_q, prev_word_d;
  logic                 prev_valid_q, prev_valid_d;
  logic [RepBits-1:0]   rep_q, rep_d;
  logic                 hold_valid_q, hold_valid_d;
  res_kind_e            hold_kind_q, hold_kind_d;
  logic [WordBits-1:0]  hold_word_q, hold_word_d;
  logic                 out_valid_q, out_valid_d;
  out_res_t             out_q, out_d;

  logic [DictIdxW-1:0]  dict_idx;
  logic [WordBits-1:0]  dict_word;
  step_t                step;
  logic [BufBits-1:0]   step_buf;
  logic [CntBits-1:0]   step_cnt;
  logic                 out_free;
  logic                 req_fire;
  logic [BufBits-1:0]   chunk_aligned;

  cdr_dict u_dict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rd_idx_i   (dict_idx),
    .rd_data_o  (dict_word)
  );

  cdr_code_unit u_code (
    .buf_i        (buf_q),
    .cnt_i        (cnt_q),
    .prev_valid_i (prev_valid_q),
    .prev_word_i  (prev_word_q),
    .rep_i        (rep_q),
    .dict_word_i  (dict_word),
    .dict_idx_o   (dict_idx),
    .step_o       (step),
    .buf_o        (step_buf),
    .cnt_o        (step_cnt)
  );

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // new chunk lands right behind the carried bits
  assign chunk_aligned = {req_i.data.stream_chunk, {PendBits{1'b0}}} >> cnt_q;

  always_comb begin
    state_d      = state_q;
    buf_d        = buf_q;
    cnt_d        = cnt_q;
    eos_d        = eos_q;
    prev_word_d  = prev_word_q;
    prev_valid_d = prev_valid_q;
    rep_d        = rep_q;
    hold_valid_d = hold_valid_q;
    hold_kind_d  = hold_kind_q;
    hold_word_d  = hold_word_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_d        = out_q;

    case (state_q)
      StIdle: begin
        if (req_fire) begin
          buf_d   = buf_q | chunk_aligned;
          cnt_d   = cnt_q + CntBits'(ChunkBits);
          eos_d   = req_i.data.end_of_stream;
          rep_d   = '0;
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (out_free) begin
          if (hold_valid_q) begin
            out_valid_d       = 1'b1;
            out_d.result_kind = hold_kind_q;
            out_d.decoded_word = hold_word_q;
            out_d.last_of_run = !step.emit;
          end
          if (step.emit) begin
            hold_valid_d = 1'b1;
            hold_kind_d  = step.kind;
            hold_word_d  = step.word;
            buf_d        = step_buf;
            cnt_d        = step_cnt;
            rep_d        = step.rep_next;
            if (step.set_prev) begin
              prev_word_d  = step.word;
              prev_valid_d = 1'b1;
            end
          end else begin
            // no complete code left: close the request
            hold_valid_d = 1'b0;
            state_d      = StIdle;
            if (eos_q) begin
              buf_d        = '0;
              cnt_d        = '0;
              prev_word_d  = '0;
              prev_valid_d = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      buf_q        <= '0;
      cnt_q        <= '0;
      eos_q        <= 1'b0;
      prev_word_q  <= '0;
      prev_valid_q <= 1'b0;
      rep_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      buf_q        <= buf_d;
      cnt_q        <= cnt_d;
      eos_q        <= eos_d;
      prev_word_q  <= prev_word_d;
      prev_valid_q <= prev_valid_d;
      rep_q        <= rep_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hold_kind_q <= hold_kind_d;
    hold_word_q <= hold_word_d;
    out_q       <= out_d;
  end

endmodule

[rtl/cdr_dict.sv]
module cdr_dict (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cdr_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [cdr_pkg::CfgBits-1:0]      cfg_data_i,
  input  logic [cdr_pkg::DictIdxW-1:0]     rd_idx_i,
  output logic [cdr_pkg::WordBits-1:0]     rd_data_o
);
  import cdr_pkg::*;

  logic [WordBits-1:0] entry_q [DictDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DictDepth; i++) begin
        entry_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxBits'(DictDepth))) begin
      entry_q[cfg_idx_i[DictIdxW-1:0]] <= cfg_data_i[WordBits-1:0];
    end
  end

  assign rd_data_o = entry_q[rd_idx_i];

endmodule

[rtl/cdr_code_unit.sv]
module cdr_code_unit (
  input  logic [cdr_pkg::BufBits-1:0]   buf_i,
  input  logic [cdr_pkg::CntBits-1:0]   cnt_i,
  input  logic                          prev_valid_i,
  input  logic [cdr_pkg::WordBits-1:0]  prev_word_i,
  input  logic [cdr_pkg::RepBits-1:0]   rep_i,
  input  logic [cdr_pkg::WordBits-1:0]  dict_word_i,
  output logic [cdr_pkg::DictIdxW-1:0]  dict_idx_o,
  output cdr_pkg::step_t                step_o,
  output logic [cdr_pkg::BufBits-1:0]   buf_o,
  output logic [cdr_pkg::CntBits-1:0]   cnt_o
);
  import cdr_pkg::*;

  logic [2:0]           prefix;
  logic [RepBits-1:0]   run_cnt;
  logic [ShiftBits-1:0] shamt;

  assign prefix     = buf_i[BufBits-1 -: PfxLen];
  assign dict_idx_o = buf_i[BufBits-1-PfxLen -: DictIdxW];
  assign run_cnt    = buf_i[BufBits-1-PfxLen -: RepBits];

  always_comb begin
    step_o   = '0;
    step_o.kind = KindWord;
    step_o.rep_next = rep_i;
    shamt    = '0;
    if (cnt_i >= CntBits'(PfxLen)) begin
      case (prefix)
        PfxRaw: begin
          if (cnt_i >= CntBits'(RawLen)) begin
            step_o.emit     = 1'b1;
            step_o.word     = buf_i[BufBits-1-PfxLen -: WordBits];
            step_o.set_prev = 1'b1;
            shamt           = ShiftBits'(RawLen);
          end
        end
        PfxDict: begin
          if (cnt_i >= CntBits'(DictLen)) begin
            step_o.emit     = 1'b1;
            step_o.word     = dict_word_i;
            step_o.set_prev = 1'b1;
            shamt           = ShiftBits'(DictLen);
          end
        end
        PfxRun: begin
          if (!prev_valid_i) begin
            step_o.emit = 1'b1;
            step_o.kind = KindNoPrior;
            shamt       = ShiftBits'(PfxLen);
          end else if (cnt_i >= CntBits'(RunLen)) begin
            step_o.emit = 1'b1;
            step_o.word = prev_word_i;
            // one repeat a step, code consumed with the final one
            if (rep_i == run_cnt) begin
              step_o.rep_next = '0;
              shamt           = ShiftBits'(RunLen);
            end else begin
              step_o.rep_next = rep_i + RepBits'(1);
            end
          end
        end
        default: begin
          step_o.emit = 1'b1;
          step_o.kind = KindBadPrefix;
          shamt       = ShiftBits'(PfxLen);
        end
      endcase
    end
  end

  assign buf_o = buf_i << shamt;
  assign cnt_o = cnt_i - CntBits'(shamt);

endmodule
